@@ rtl/core/vector_radius_clamp_macros.svh @@
// Assertion macros for the vector_radius_clamp checker.
// Expects clk_i and rst_ni in the scope of use.
`ifndef VECTOR_RADIUS_CLAMP_MACROS_SVH
`define VECTOR_RADIUS_CLAMP_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define VRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a condition in the next cycle
`define VRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/vrc_pkg.sv @@
// Shared constants for the vector radius clamp: field widths, fixed-point
// format, register map and reset values. No dependencies.
package vrc_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF    = 12;
  localparam int CORDIC_STAGES_DEF = 16;

  // Fixed field widths
  localparam int CENTER_BITS = 10;
  localparam int RADIUS_BITS = 7;

  // Fixed-point format: 8 fraction bits, rotation datapath width
  localparam int FRAC_BITS = 8;
  localparam int ROT_BITS  = 18;
  localparam int GAIN_BITS = 16;
  localparam logic [GAIN_BITS-1:0] GAIN_INV = 16'd39797;

  // Register stages before and after the CORDIC chain
  localparam int PRE_STAGES  = 3;
  localparam int POST_STAGES = 2;

  // Configuration port
  localparam int PADDR_BITS   = 5;
  localparam int PDATA_BITS   = 32;
  localparam int REG_IDX_BITS = PADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_LEFT_CX    = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_LEFT_CY    = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_RIGHT_CX   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_RIGHT_CY   = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_RADIUS = 3'd4;

  // Reset values
  localparam logic [CENTER_BITS-1:0] LEFT_CX_RST  = 10'd315;
  localparam logic [CENTER_BITS-1:0] LEFT_CY_RST  = 10'd300;
  localparam logic [CENTER_BITS-1:0] RIGHT_CX_RST = 10'd485;
  localparam logic [CENTER_BITS-1:0] RIGHT_CY_RST = 10'd300;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RST   = 7'd45;

endpackage

@@ rtl/core/vrc_lane.sv @@
// Clamp datapath for one center: offset, disc test, CORDIC chain, rounding.
// Depends on vrc_pkg.
module vrc_lane #(
  parameter int COORD_BITS    = vrc_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = vrc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [COORD_BITS-1:0]        cursor_x_i,
  input  logic signed [COORD_BITS-1:0]        cursor_y_i,
  input  logic [vrc_pkg::CENTER_BITS-1:0]     center_x_i,
  input  logic [vrc_pkg::CENTER_BITS-1:0]     center_y_i,
  input  logic [vrc_pkg::RADIUS_BITS-1:0]     max_radius_i,
  output logic signed [COORD_BITS-1:0]        follow_x_o,
  output logic signed [COORD_BITS-1:0]        follow_y_o
);
  import vrc_pkg::*;

  // Offset width holds cursor minus center and its negation
  localparam int DW = ((COORD_BITS > CENTER_BITS + 1) ? COORD_BITS : CENTER_BITS + 1) + 1;
  localparam int SQ_BITS   = 2 * DW - 2;
  localparam int SUM_BITS  = 2 * DW - 1;
  localparam int RR_BITS   = 2 * RADIUS_BITS;
  // Vectoring width: Q8 plus two bits for CORDIC growth
  localparam int VW        = DW + FRAC_BITS + 2;
  localparam int PROD_BITS = RADIUS_BITS + GAIN_BITS;
  localparam int OFS_BITS  = ROT_BITS - FRAC_BITS;
  localparam int SW = (COORD_BITS > CENTER_BITS + 2) ? COORD_BITS : CENTER_BITS + 2;

  localparam logic [PROD_BITS-1:0]       PROD_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [ROT_BITS-1:0] ROT_HALF  = ROT_BITS'(1) << (FRAC_BITS - 1);

  // Stage 1: offsets from center
  logic signed [DW-1:0]         s1_dx_q, s1_dy_q;
  logic signed [COORD_BITS-1:0] s1_px_q, s1_py_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_dx_q <= DW'(cursor_x_i) - DW'(center_x_i);
      s1_dy_q <= DW'(cursor_y_i) - DW'(center_y_i);
      s1_px_q <= cursor_x_i;
      s1_py_q <= cursor_y_i;
    end
  end

  // Stage 2: squares and half-plane fold
  logic signed [2*DW-1:0]       dx_sq, dy_sq;
  logic                         fold;
  logic [SQ_BITS-1:0]           s2_sqx_q, s2_sqy_q;
  logic signed [DW-1:0]         s2_fx_q, s2_fy_q;
  logic                         s2_fold_q;
  logic signed [COORD_BITS-1:0] s2_px_q, s2_py_q;

  assign dx_sq = s1_dx_q * s1_dx_q;
  assign dy_sq = s1_dy_q * s1_dy_q;
  assign fold  = s1_dx_q[DW-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sqx_q  <= dx_sq[SQ_BITS-1:0];
      s2_sqy_q  <= dy_sq[SQ_BITS-1:0];
      s2_fx_q   <= fold ? -s1_dx_q : s1_dx_q;
      s2_fy_q   <= fold ? -s1_dy_q : s1_dy_q;
      s2_fold_q <= fold;
      s2_px_q   <= s1_px_q;
      s2_py_q   <= s1_py_q;
    end
  end

  // Stage 3: disc test, Q8 load, rotation seed from the radius
  logic [SUM_BITS-1:0]  sq_sum;
  logic [RR_BITS-1:0]   rr;
  logic [PROD_BITS-1:0] seed_prod, seed_rnd;

  assign sq_sum    = SUM_BITS'(s2_sqx_q) + SUM_BITS'(s2_sqy_q);
  assign rr        = max_radius_i * max_radius_i;
  assign seed_prod = PROD_BITS'(max_radius_i) * PROD_BITS'(GAIN_INV);
  assign seed_rnd  = seed_prod + PROD_HALF;

  // CORDIC chain registers; entry 0 is the stage 3 output
  logic signed [VW-1:0]         c_x_q    [CORDIC_STAGES+1];
  logic signed [VW-1:0]         c_y_q    [CORDIC_STAGES+1];
  logic signed [ROT_BITS-1:0]   c_u_q    [CORDIC_STAGES+1];
  logic signed [ROT_BITS-1:0]   c_v_q    [CORDIC_STAGES+1];
  logic                         c_in_q   [CORDIC_STAGES+1];
  logic                         c_fold_q [CORDIC_STAGES+1];
  logic signed [COORD_BITS-1:0] c_px_q   [CORDIC_STAGES+1];
  logic signed [COORD_BITS-1:0] c_py_q   [CORDIC_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_x_q[0]    <= VW'(s2_fx_q) <<< FRAC_BITS;
      c_y_q[0]    <= VW'(s2_fy_q) <<< FRAC_BITS;
      c_u_q[0]    <= ROT_BITS'(seed_rnd >> FRAC_BITS);
      c_v_q[0]    <= '0;
      c_in_q[0]   <= (sq_sum <= SUM_BITS'(rr));
      c_fold_q[0] <= s2_fold_q;
      c_px_q[0]   <= s2_px_q;
      c_py_q[0]   <= s2_py_q;
    end
  end

  // One vectoring step and the matching reverse rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic                       dir;
    logic signed [VW-1:0]       xs, ys;
    logic signed [ROT_BITS-1:0] us, vs;

    assign dir = !c_y_q[i][VW-1];
    assign xs  = c_x_q[i] >>> i;
    assign ys  = c_y_q[i] >>> i;
    assign us  = c_u_q[i] >>> i;
    assign vs  = c_v_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_x_q[i+1]    <= dir ? c_x_q[i] + ys : c_x_q[i] - ys;
        c_y_q[i+1]    <= dir ? c_y_q[i] - xs : c_y_q[i] + xs;
        c_u_q[i+1]    <= dir ? c_u_q[i] - vs : c_u_q[i] + vs;
        c_v_q[i+1]    <= dir ? c_v_q[i] + us : c_v_q[i] - us;
        c_in_q[i+1]   <= c_in_q[i];
        c_fold_q[i+1] <= c_fold_q[i];
        c_px_q[i+1]   <= c_px_q[i];
        c_py_q[i+1]   <= c_py_q[i];
      end
    end
  end

  // Post stage 1: round to whole pixels, half up
  logic signed [ROT_BITS-1:0]   u_rnd, v_rnd;
  logic signed [OFS_BITS-1:0]   r1_ou_q, r1_ov_q;
  logic                         r1_in_q, r1_fold_q;
  logic signed [COORD_BITS-1:0] r1_px_q, r1_py_q;

  assign u_rnd = c_u_q[CORDIC_STAGES] + ROT_HALF;
  assign v_rnd = c_v_q[CORDIC_STAGES] + ROT_HALF;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_ou_q   <= OFS_BITS'(u_rnd >>> FRAC_BITS);
      r1_ov_q   <= OFS_BITS'(v_rnd >>> FRAC_BITS);
      r1_in_q   <= c_in_q[CORDIC_STAGES];
      r1_fold_q <= c_fold_q[CORDIC_STAGES];
      r1_px_q   <= c_px_q[CORDIC_STAGES];
      r1_py_q   <= c_py_q[CORDIC_STAGES];
    end
  end

  // Post stage 2: unfold, add center, pick cursor when inside the disc
  logic signed [SW-1:0]         cen_x, cen_y, ofs_x, ofs_y, pos_x, pos_y;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;

  assign cen_x = SW'(center_x_i);
  assign cen_y = SW'(center_y_i);
  assign ofs_x = SW'(r1_ou_q);
  assign ofs_y = SW'(r1_ov_q);
  assign pos_x = r1_fold_q ? cen_x - ofs_x : cen_x + ofs_x;
  assign pos_y = r1_fold_q ? cen_y - ofs_y : cen_y + ofs_y;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_x_q <= r1_in_q ? r1_px_q : COORD_BITS'(pos_x);
      out_y_q <= r1_in_q ? r1_py_q : COORD_BITS'(pos_y);
    end
  end

  assign follow_x_o = out_x_q;
  assign follow_y_o = out_y_q;

endmodule

@@ rtl/core/vector_radius_clamp.sv @@
// Channel   Signals                                   Width / notes
// cfg       psel penable pwrite paddr pwdata prdata   5-bit byte address, 32-bit data
// in        in_valid_i in_ready_o cursor_x/y_i        COORD_BITS signed each
// out       out_valid_o out_ready_i left/right_*_o    COORD_BITS signed each
//
// One item per cycle unless both output queue entries wait; each item passes three front stages,
// one CORDIC step per stage, the round and recenter stages and the queue head.
// A two-entry output queue follows the pipeline; the whole pipeline holds only
// while both entries wait, so one result may wait without blocking input.
// Reset clears valid bits and the queue count and loads the register defaults.
// Top level of the vector radius clamp. Depends on vrc_pkg and vrc_lane.
module vector_radius_clamp #(
  parameter int COORD_BITS    = vrc_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = vrc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vrc_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [vrc_pkg::PDATA_BITS-1:0]   pwdata,
  output logic [vrc_pkg::PDATA_BITS-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [COORD_BITS-1:0]     cursor_x_i,
  input  logic signed [COORD_BITS-1:0]     cursor_y_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [COORD_BITS-1:0]     left_follow_x_o,
  output logic signed [COORD_BITS-1:0]     left_follow_y_o,
  output logic signed [COORD_BITS-1:0]     right_follow_x_o,
  output logic signed [COORD_BITS-1:0]     right_follow_y_o
);
  import vrc_pkg::*;

  localparam int LAT = PRE_STAGES + CORDIC_STAGES + POST_STAGES;
  localparam logic [1:0] Q_EMPTY = 2'd0;
  localparam logic [1:0] Q_FULL  = 2'd2;

  // Configuration registers
  logic [CENTER_BITS-1:0]  left_cx_q, left_cy_q, right_cx_q, right_cy_q;
  logic [RADIUS_BITS-1:0]  radius_q;
  logic [REG_IDX_BITS-1:0] cfg_idx;
  logic                    cfg_wr;

  assign cfg_idx = paddr[PADDR_BITS-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cx_q  <= LEFT_CX_RST;
      left_cy_q  <= LEFT_CY_RST;
      right_cx_q <= RIGHT_CX_RST;
      right_cy_q <= RIGHT_CY_RST;
      radius_q   <= RADIUS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LEFT_CX:    left_cx_q  <= pwdata[CENTER_BITS-1:0];
        REG_LEFT_CY:    left_cy_q  <= pwdata[CENTER_BITS-1:0];
        REG_RIGHT_CX:   right_cx_q <= pwdata[CENTER_BITS-1:0];
        REG_RIGHT_CY:   right_cy_q <= pwdata[CENTER_BITS-1:0];
        REG_MAX_RADIUS: radius_q   <= pwdata[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_LEFT_CX:    prdata = PDATA_BITS'(left_cx_q);
      REG_LEFT_CY:    prdata = PDATA_BITS'(left_cy_q);
      REG_RIGHT_CX:   prdata = PDATA_BITS'(right_cx_q);
      REG_RIGHT_CY:   prdata = PDATA_BITS'(right_cy_q);
      REG_MAX_RADIUS: prdata = PDATA_BITS'(radius_q);
      default:        prdata = '0;
    endcase
  end

  // Pipeline advance: hold everything only while the output queue is full
  logic [1:0]     cnt_q, cnt_d;
  logic           adv;
  logic [LAT-1:0] vld_q;
  logic           push, pop;

  assign adv        = (cnt_q != Q_FULL);
  assign in_ready_o = adv;
  assign push       = adv & vld_q[LAT-1];
  assign out_valid_o = (cnt_q != Q_EMPTY);
  assign pop        = out_valid_o & out_ready_i;

  // Shift valid bits alongside the lane data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // One datapath per center
  logic [3:0][COORD_BITS-1:0] lane_res;

  vrc_lane #(
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_left (
    .clk_i       (clk_i),
    .en_i        (adv),
    .cursor_x_i  (cursor_x_i),
    .cursor_y_i  (cursor_y_i),
    .center_x_i  (left_cx_q),
    .center_y_i  (left_cy_q),
    .max_radius_i(radius_q),
    .follow_x_o  (lane_res[0]),
    .follow_y_o  (lane_res[1])
  );

  vrc_lane #(
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_right (
    .clk_i       (clk_i),
    .en_i        (adv),
    .cursor_x_i  (cursor_x_i),
    .cursor_y_i  (cursor_y_i),
    .center_x_i  (right_cx_q),
    .center_y_i  (right_cy_q),
    .max_radius_i(radius_q),
    .follow_x_o  (lane_res[2]),
    .follow_y_o  (lane_res[3])
  );

  // Two-entry output queue: head drives the ports, tail holds a second item
  logic [3:0][COORD_BITS-1:0] head_q, head_d, tail_q, tail_d;

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    priority if (push && pop) begin
      head_d = lane_res;
    end else if (push) begin
      if (cnt_q == Q_EMPTY) begin
        head_d = lane_res;
      end else begin
        tail_d = lane_res;
      end
      cnt_d = cnt_q + 2'd1;
    end else if (pop) begin
      head_d = tail_q;
      cnt_d  = cnt_q - 2'd1;
    end else begin
      // Hold the queue
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= Q_EMPTY;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign left_follow_x_o  = head_q[0];
  assign left_follow_y_o  = head_q[1];
  assign right_follow_x_o = head_q[2];
  assign right_follow_y_o = head_q[3];

endmodule

@@ rtl/core/vrc_checker.sv @@
// Port-level checks for vector_radius_clamp, bound to the top level.
// Depends on vrc_pkg and vector_radius_clamp_macros.svh.
`include "vector_radius_clamp_macros.svh"

module vrc_checker #(
  parameter int COORD_BITS = vrc_pkg::COORD_BITS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [vrc_pkg::PADDR_BITS-1:0]   paddr,
  input logic [vrc_pkg::PDATA_BITS-1:0]   pwdata,
  input logic [vrc_pkg::PDATA_BITS-1:0]   prdata,
  input logic                             pready,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [COORD_BITS-1:0]     left_follow_x_o,
  input logic signed [COORD_BITS-1:0]     left_follow_y_o,
  input logic signed [COORD_BITS-1:0]     right_follow_x_o,
  input logic signed [COORD_BITS-1:0]     right_follow_y_o
);
  import vrc_pkg::*;

  logic                    out_wait;
  logic [4*COORD_BITS-1:0] out_bus;
  logic                    rad_sel, rad_wr;
  logic [PDATA_BITS-1:0]   rad_wd;

  assign out_wait = out_valid_o && !out_ready_i;
  assign out_bus  = {left_follow_x_o, left_follow_y_o, right_follow_x_o, right_follow_y_o};
  assign rad_sel  = (paddr[PADDR_BITS-1:2] == REG_MAX_RADIUS);
  assign rad_wr   = psel && penable && pwrite && rad_sel;
  assign rad_wd   = PDATA_BITS'(pwdata[RADIUS_BITS-1:0]);

  // Register port never waits
  `VRC_ASSERT(a_pready_high, pready, "pready dropped")

  // Input stalls only while results are waiting at the output
  `VRC_ASSERT(a_stall_has_result, (!in_ready_o |-> out_valid_o), "input stalled with no result")

  // Taking a result out of a full queue reopens the input
  `VRC_ASSERT_NEXT(a_stall_release, !in_ready_o && out_ready_i, in_ready_o, "stall not released")

  // A waiting result holds its value
  `VRC_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_bus), "result changed")

  // Radius readback after a write shows the written low bits
  `VRC_ASSERT_NEXT(a_radius_rdback, rad_wr, !rad_sel || prdata == $past(rad_wd), "radius readback")

endmodule

bind vector_radius_clamp vrc_checker #(.COORD_BITS(COORD_BITS)) u_vrc_checker (.*);

@@ verif/tb_vector_radius_clamp.sv @@
// Self-checking testbench for vector_radius_clamp: drives cursor items and APB register
// writes, predicts both clamped followers with a CORDIC model of its own, checks results.
// Depends on vrc_pkg and the vector_radius_clamp RTL.
module tb_vector_radius_clamp;
  timeunit 1ns;
  timeprecision 1ps;

  import vrc_pkg::*;

  localparam int CW            = COORD_BITS_DEF;
  localparam int STAGES        = CORDIC_STAGES_DEF;
  localparam int FRAC          = 8;
  localparam longint INV_GAIN_Q16 = 39797;
  localparam int DRAIN_CYCLES  = STAGES + 5 + 8;
  localparam int QUIET_LIMIT   = 4000;
  localparam int STALL_CYCLES  = 400;
  localparam int IDLE_PCT      = 7;
  localparam int SHOW_MAX      = 10;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } cursor_t;

  typedef struct {
    logic signed [CW-1:0] lx;
    logic signed [CW-1:0] ly;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
  } follow_t;

  // DUT signals
  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_BITS-1:0]  paddr;
  logic [PDATA_BITS-1:0]  pwdata;
  logic [PDATA_BITS-1:0]  prdata;
  logic                   pready;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic signed [CW-1:0]   cursor_x_i;
  logic signed [CW-1:0]   cursor_y_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic signed [CW-1:0]   left_follow_x_o;
  logic signed [CW-1:0]   left_follow_y_o;
  logic signed [CW-1:0]   right_follow_x_o;
  logic signed [CW-1:0]   right_follow_y_o;

  // Register copies used for prediction
  logic [CENTER_BITS-1:0] cfg_lcx;
  logic [CENTER_BITS-1:0] cfg_lcy;
  logic [CENTER_BITS-1:0] cfg_rcx;
  logic [CENTER_BITS-1:0] cfg_rcy;
  logic [RADIUS_BITS-1:0] cfg_radius;

  cursor_t cursor_q[$];
  follow_t follow_q[$];
  cursor_t next_cursor;
  follow_t want;

  int  mismatches   = 0;
  int  cursors_sent = 0;
  int  results_seen = 0;
  int  clamped_cnt  = 0;
  int  settings_cnt = 0;
  int  quiet_cycles = 0;
  int  stall_left   = 0;
  bit  stall_req    = 1'b0;
  bit  stall_taken  = 1'b0;
  bit  no_gaps      = 1'b0;

  vector_radius_clamp dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cursor_x_i       (cursor_x_i),
    .cursor_y_i       (cursor_y_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .left_follow_x_o  (left_follow_x_o),
    .left_follow_y_o  (left_follow_y_o),
    .right_follow_x_o (right_follow_x_o),
    .right_follow_y_o (right_follow_y_o)
  );

  // Clock: 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Clamp one cursor to the disc around one center; returns 1 when clamping applied
  function automatic bit clamp_to_disc(input longint ctr_x, input longint ctr_y,
                                       input longint pos_x, input longint pos_y,
                                       output logic signed [CW-1:0] fol_x,
                                       output logic signed [CW-1:0] fol_y);
    longint dx, dy, rad, x, y, u, v, t;
    bit [STAGES-1:0] turn_pos;
    bit fold;
    dx  = pos_x - ctr_x;
    dy  = pos_y - ctr_y;
    rad = longint'(cfg_radius);
    if (dx * dx + dy * dy <= rad * rad) begin
      fol_x = pos_x[CW-1:0];
      fol_y = pos_y[CW-1:0];
      return 1'b0;
    end
    // Fold into the right half plane
    fold = (dx < 0);
    if (fold) begin
      dx = -dx;
      dy = -dy;
    end
    // Vectoring: record the turn taken at each stage
    x = dx * (longint'(1) << FRAC);
    y = dy * (longint'(1) << FRAC);
    for (int i = 0; i < STAGES; i++) begin
      turn_pos[i] = (y >= 0);
      if (turn_pos[i]) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
      end else begin
        t = x - (y >>> i);
        y = y + (x >>> i);
      end
      x = t;
    end
    // Rotation of the gain-compensated radius back along the same angle
    u = (rad * INV_GAIN_Q16 + 128) >>> 8;
    v = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (turn_pos[i]) begin
        t = u - (v >>> i);
        v = v + (u >>> i);
      end else begin
        t = u + (v >>> i);
        v = v - (u >>> i);
      end
      u = t;
    end
    // Round half up to whole pixels
    u = (u + (longint'(1) << (FRAC - 1))) >>> FRAC;
    v = (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
    if (fold) begin
      u = -u;
      v = -v;
    end
    t = ctr_x + u;
    fol_x = t[CW-1:0];
    t = ctr_y + v;
    fol_y = t[CW-1:0];
    return 1'b1;
  endfunction

  // Predict both followers for one cursor item under the current registers
  function automatic follow_t predict_followers(input cursor_t cur);
    follow_t res;
    clamped_cnt += clamp_to_disc(longint'(cfg_lcx), longint'(cfg_lcy),
                                 longint'(cur.x), longint'(cur.y), res.lx, res.ly);
    clamped_cnt += clamp_to_disc(longint'(cfg_rcx), longint'(cfg_rcy),
                                 longint'(cur.x), longint'(cur.y), res.rx, res.ry);
    return res;
  endfunction

  // Input driver: record accepted items, offer the next pending one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        next_cursor.x = cursor_x_i;
        next_cursor.y = cursor_y_i;
        follow_q.push_back(predict_followers(next_cursor));
        cursors_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (cursor_q.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          next_cursor = cursor_q.pop_front();
          in_valid_i <= 1'b1;
          cursor_x_i <= next_cursor.x;
          cursor_y_i <= next_cursor.y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each result against the oldest prediction, pace ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (follow_q.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("[%0t] result with no item pending: %0d %0d %0d %0d", $realtime,
                     left_follow_x_o, left_follow_y_o, right_follow_x_o, right_follow_y_o);
        end else begin
          want = follow_q.pop_front();
          if (want.lx !== left_follow_x_o || want.ly !== left_follow_y_o ||
              want.rx !== right_follow_x_o || want.ry !== right_follow_y_o) begin
            mismatches++;
            if (mismatches <= SHOW_MAX)
              $display("[%0t] follower mismatch: expected L(%0d,%0d) R(%0d,%0d) got L(%0d,%0d) R(%0d,%0d)",
                       $realtime, want.lx, want.ly, want.rx, want.ry,
                       left_follow_x_o, left_follow_y_o, right_follow_x_o, right_follow_y_o);
          end
        end
      end
      // Hold off once for a long stretch so the pipeline backs up
      if (stall_req && !stall_taken) begin
        stall_taken <= 1'b1;
        stall_left  <= STALL_CYCLES;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Write one register over APB and update the local copy
  task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_LEFT_CX:    cfg_lcx    = data[CENTER_BITS-1:0];
      REG_LEFT_CY:    cfg_lcy    = data[CENTER_BITS-1:0];
      REG_RIGHT_CX:   cfg_rcx    = data[CENTER_BITS-1:0];
      REG_RIGHT_CY:   cfg_rcy    = data[CENTER_BITS-1:0];
      REG_MAX_RADIUS: cfg_radius = data[RADIUS_BITS-1:0];
      default: ;
    endcase
  endtask

  // Read one register over APB and compare with the local copy
  task automatic apb_read_check(input logic [REG_IDX_BITS-1:0] idx);
    logic [31:0] exp_val;
    case (idx)
      REG_LEFT_CX:    exp_val = 32'(cfg_lcx);
      REG_LEFT_CY:    exp_val = 32'(cfg_lcy);
      REG_RIGHT_CX:   exp_val = 32'(cfg_rcx);
      REG_RIGHT_CY:   exp_val = 32'(cfg_rcy);
      default:        exp_val = 32'(cfg_radius);
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    // Sample mid-way through the access phase
    @(negedge clk_i);
    if (prdata !== exp_val) begin
      mismatches++;
      if (mismatches <= SHOW_MAX)
        $display("[%0t] register %0d read: expected %0d got %0d", $realtime, idx,
                 exp_val, prdata);
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Load a full register setting with junk in the upper bits, poke a spare index,
  // then read everything back
  task automatic load_settings(input int lcx, input int lcy, input int rcx, input int rcy,
                               input int rad);
    logic [REG_IDX_BITS-1:0] spare;
    spare = REG_MAX_RADIUS + REG_IDX_BITS'($urandom_range(1, 3));
    apb_write(REG_LEFT_CX,    ($urandom() << CENTER_BITS) | lcx);
    apb_write(REG_LEFT_CY,    ($urandom() << CENTER_BITS) | lcy);
    apb_write(REG_RIGHT_CX,   ($urandom() << CENTER_BITS) | rcx);
    apb_write(REG_RIGHT_CY,   ($urandom() << CENTER_BITS) | rcy);
    apb_write(REG_MAX_RADIUS, ($urandom() << RADIUS_BITS) | rad);
    apb_write(spare, $urandom());
    for (int i = REG_LEFT_CX; i <= REG_MAX_RADIUS; i++)
      apb_read_check(REG_IDX_BITS'(i));
    settings_cnt++;
  endtask

  task automatic push_cursor(input int x, input int y);
    cursor_t cur;
    cur.x = x[CW-1:0];
    cur.y = y[CW-1:0];
    cursor_q.push_back(cur);
  endtask

  // Queue random cursors: mostly near a center, the rest anywhere
  task automatic push_random(input int count);
    int span, mode;
    span = 2 * int'(cfg_radius) + 4;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(9);
      if (mode < 4)
        push_cursor(int'(cfg_lcx) + int'($urandom_range(2 * span)) - span,
                    int'(cfg_lcy) + int'($urandom_range(2 * span)) - span);
      else if (mode < 7)
        push_cursor(int'(cfg_rcx) + int'($urandom_range(2 * span)) - span,
                    int'(cfg_rcy) + int'($urandom_range(2 * span)) - span);
      else
        push_cursor($urandom_range(4095), $urandom_range(4095));
    end
  endtask

  // Wait until every item is sent and every result is back, then let the pipe drain
  task automatic wait_idle();
    while (cursor_q.size() != 0 || in_valid_i || follow_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    cursor_x_i  = '0;
    cursor_y_i  = '0;
    out_ready_i = 1'b0;
    cfg_lcx     = 10'd315;
    cfg_lcy     = 10'd300;
    cfg_rcx     = 10'd485;
    cfg_rcy     = 10'd300;
    cfg_radius  = 7'd45;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values must read back
    for (int i = REG_LEFT_CX; i <= REG_MAX_RADIUS; i++)
      apb_read_check(REG_IDX_BITS'(i));

    // Directed: centers, disc boundary, fold, field extremes
    push_cursor(315, 300);
    push_cursor(485, 300);
    push_cursor(360, 300);
    push_cursor(361, 300);
    push_cursor(342, 336);
    push_cursor(315, 345);
    push_cursor(270, 300);
    push_cursor(269, 300);
    push_cursor(100, 250);
    push_cursor(315, 0);
    push_cursor(-2048, -2048);
    push_cursor(2047, 2047);
    push_cursor(-2048, 2047);
    push_cursor(2047, -2048);
    push_cursor(0, 0);
    push_cursor(-1, -1);
    push_random(260);
    wait_idle();

    // Zero radius: only the center itself stays put
    load_settings($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023), 0);
    push_cursor(cfg_lcx, cfg_lcy);
    push_cursor(cfg_lcx + 1, cfg_lcy);
    push_cursor(cfg_rcx, cfg_rcy - 1);
    push_random(260);
    wait_idle();

    // Largest radius, centers at the corners; back up the pipe with a long stall
    load_settings(0, 0, 1023, 1023, 127);
    push_cursor(127, 0);
    push_cursor(0, -127);
    push_cursor(1023, 1151);
    push_cursor(-2048, -2048);
    push_random(300);
    while (cursor_q.size() > 200) @(posedge clk_i);
    stall_req <= 1'b1;
    wait_idle();

    // Unit radius, opposite corners, no idling on either side
    load_settings(1023, 0, 0, 1023, 1);
    no_gaps <= 1'b1;
    push_random(260);
    wait_idle();
    no_gaps <= 1'b0;

    // Random settings
    repeat (2) begin
      load_settings($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                    $urandom_range(1023), $urandom_range(127));
      push_random(300);
      wait_idle();
    end

    if (follow_q.size() != 0) begin
      mismatches += follow_q.size();
      $display("%0d predicted results never arrived", follow_q.size());
    end

    $display("Covered %0d cursor items and %0d results over %0d register settings,",
             cursors_sent, results_seen, settings_cnt + 1);
    $display("with %0d follower positions clamped to the disc edge; %0d failures",
             clamped_cnt, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/vrc_pkg.sv
rtl/core/vrc_lane.sv
rtl/core/vector_radius_clamp.sv
rtl/core/vrc_checker.sv
verif/tb_vector_radius_clamp.sv
